### rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W    = 8;
    localparam int ROW_W    = 16;
    localparam int OCOL_W   = 10;
    localparam int MAG_W    = 11;
    localparam int GRAD_W   = 11;
    localparam int SQ_W     = 22;
    localparam int CFGW_W   = 11;
    localparam int CFGH_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_TDATA_W = 40;
    localparam int Q_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFGW_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [CFGH_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic [OCOL_W-1:0]        col;
        logic                     last;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } sem_job_t;

    typedef struct packed {
        logic push;
        logic pop;
    } sem_q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sem_q_stat_t;

endpackage

### rtl/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// Pixel intake: raster counters, line buffer memory, 3x3 window and gradients.
// ----------------------------------------------------------------------------
module sem_front
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    output logic                  q_push,
    output sem_job_t              q_job
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW_W = $clog2(MAX_WIDTH + 1);

    logic [CFGW_W-1:0]      width_reg;
    logic [CFGH_W-1:0]      height_reg;
    logic [CW-1:0]          col_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [EW_W-1:0]        eff_w;
    logic [ROW_W-1:0]       eff_h;

    logic                   valid_a_reg;
    logic [PIX_W-1:0]       px_a_reg;
    logic [CW-1:0]          col_a_reg;
    logic [ROW_W-1:0]       row_a_reg;
    logic                   interior_a_reg;
    logic                   last_a_reg;
    logic [2*PIX_W-1:0]     rd_reg;

    logic [2*PIX_W-1:0]     line_mem [MAX_WIDTH];
    logic [PIX_W-1:0]       win_reg [2][3];

    logic                   accept_s;
    logic                   fire_b;
    logic                   interior;
    logic                   last;
    logic                   col_wrap;
    logic                   row_wrap;
    logic [PIX_W-1:0]       new_col [3];
    logic [11:0]            gx_pos, gx_neg, gy_pos, gy_neg, gx_w, gy_w;
    logic [31:0]            col_less1;

    always_comb
    begin
        eff_w = EW_W'(MAX_WIDTH);
        if (32'(width_reg) < 32'd3)
            eff_w = EW_W'(3);
        else if (32'(width_reg) <= 32'(MAX_WIDTH))
            eff_w = EW_W'(width_reg);
        eff_h = (height_reg < 16'd3) ? 16'd3 : height_reg;
    end

    assign accept_s = s_tvalid && s_tready;
    assign fire_b   = valid_a_reg && (!interior_a_reg || !q_full);
    assign s_tready = !valid_a_reg || fire_b;
    assign q_push   = fire_b && interior_a_reg;

    assign col_wrap = (32'(col_reg) + 32'd1) >= 32'(eff_w);
    assign row_wrap = (32'(row_reg) + 32'd1) >= 32'(eff_h);
    assign interior = (row_reg >= 16'd2) && (32'(col_reg) >= 32'd2)
                      && (32'(col_reg) < 32'(eff_w)) && (row_reg < eff_h);
    assign last     = (32'(row_reg) == 32'(eff_h) - 32'd1)
                      && (32'(col_reg) == 32'(eff_w) - 32'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= IMAGE_WIDTH_RST;
            height_reg     <= IMAGE_HEIGHT_RST;
            col_reg        <= '0;
            row_reg        <= '0;
            valid_a_reg    <= 1'b0;
            interior_a_reg <= 1'b0;
            last_a_reg     <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[CFGW_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[CFGH_W-1:0];
                    default: ;
                endcase
            end
            if (accept_s)
            begin
                valid_a_reg    <= 1'b1;
                px_a_reg       <= s_tdata;
                col_a_reg      <= col_reg;
                row_a_reg      <= row_reg;
                interior_a_reg <= interior;
                last_a_reg     <= last;
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : row_reg + 16'd1;
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            else if (fire_b)
            begin
                valid_a_reg <= 1'b0;
            end
            if (fire_b)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[0][j] <= win_reg[1][j];
                    win_reg[1][j] <= new_col[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_s)
            rd_reg <= line_mem[col_reg];
        if (fire_b)
            line_mem[col_a_reg] <= {rd_reg[PIX_W-1:0], px_a_reg};
    end

    assign new_col[0] = rd_reg[2*PIX_W-1:PIX_W];
    assign new_col[1] = rd_reg[PIX_W-1:0];
    assign new_col[2] = px_a_reg;

    always_comb
    begin
        gx_pos = 12'(new_col[0]) + {3'b0, new_col[1], 1'b0} + 12'(new_col[2]);
        gx_neg = 12'(win_reg[0][0]) + {3'b0, win_reg[0][1], 1'b0} + 12'(win_reg[0][2]);
        gy_pos = 12'(win_reg[0][2]) + {3'b0, win_reg[1][2], 1'b0} + 12'(new_col[2]);
        gy_neg = 12'(win_reg[0][0]) + {3'b0, win_reg[1][0], 1'b0} + 12'(new_col[0]);
        gx_w   = gx_pos - gx_neg;
        gy_w   = gy_pos - gy_neg;
    end

    assign col_less1 = 32'(col_a_reg) - 32'd1;

    assign q_job.row  = row_a_reg - 16'd1;
    assign q_job.col  = col_less1[OCOL_W-1:0];
    assign q_job.last = last_a_reg;
    assign q_job.gx   = gx_w[GRAD_W-1:0];
    assign q_job.gy   = gy_w[GRAD_W-1:0];

endmodule

### rtl/sem_queue.sv
// ----------------------------------------------------------------------------
// sem_queue
// Short job queue between the intake front and the square-root back end.
// ----------------------------------------------------------------------------
module sem_queue
    import sem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sem_q_ctrl_t ctrl,
    input  sem_job_t    wr_job,
    output sem_job_t    rd_job,
    output sem_q_stat_t stat
);

    localparam int QP_W = $clog2(Q_DEPTH);
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    sem_job_t           slot_reg [Q_DEPTH];
    logic [QP_W-1:0]    wr_ptr_reg;
    logic [QP_W-1:0]    rd_ptr_reg;
    logic [QC_W-1:0]    count_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (count_reg == QC_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = ctrl.push && !stat.full;
    assign do_pop     = ctrl.pop && !stat.empty;
    assign rd_job     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                slot_reg[wr_ptr_reg] <= wr_job;
                wr_ptr_reg <= (32'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + QP_W'(1);
            end
            if (do_pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + QP_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QC_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QC_W'(1);
        end
    end

endmodule

### rtl/sem_back.sv
// ----------------------------------------------------------------------------
// sem_back
// Back end: squares the gradients, takes the integer square root one result
// bit per cycle and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module sem_back
    import sem_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sem_job_t               q_job,
    input  logic                   q_empty,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    typedef enum logic [2:0] {ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_DONE} state_t;

    state_t                   state_reg;
    sem_job_t                 job_reg;
    logic [SQ_W-1:0]          acc_reg;
    logic [SQ_W-1:0]          root_reg;
    logic [SQ_W-1:0]          bit_reg;
    logic [OUT_TDATA_W-1:0]   tdata_reg;
    logic                     tlast_reg;
    logic                     tvalid_reg;

    logic signed [SQ_W-1:0]   sq_x;
    logic signed [SQ_W-1:0]   sq_y;
    logic [SQ_W-1:0]          trial;
    logic                     out_free;

    assign sq_x     = job_reg.gx * job_reg.gx;
    assign sq_y     = job_reg.gy * job_reg.gy;
    assign trial    = root_reg + bit_reg;
    assign out_free = !tvalid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            if (tvalid_reg && m_tready && state_reg != ST_DONE)
                tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg   <= q_job;
                        state_reg <= ST_SQX;
                    end
                end
                ST_SQX:
                begin
                    acc_reg   <= $unsigned(sq_x);
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    acc_reg   <= acc_reg + $unsigned(sq_y);
                    root_reg  <= '0;
                    bit_reg   <= SQ_W'(1) << (SQ_W - 2);
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (acc_reg >= trial)
                    begin
                        acc_reg  <= acc_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        tdata_reg  <= {3'b000, root_reg[MAG_W-1:0], job_reg.col, job_reg.row};
                        tlast_reg  <= job_reg.last;
                        tvalid_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

### rtl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Sobel edge magnitude over a raster stream of 8-bit grayscale pixels.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while the job queue has room; a border pixel
// needs no queue slot and only waits behind an interior pixel that does. Each
// interior pixel becomes a job that the back end turns into
// floor(sqrt(gx*gx + gy*gy)) through pop, two squaring steps, 11 square-root
// steps and output load; the back end takes a new job only when it is through
// with the last job, so the bit-serial square-root loop sets the sustained rate.
// The four-entry queue, together with the intake register and the job held in
// an idle back end, lets a run of six interior pixels in at full speed. Line
// buffers are one memory of MAX_WIDTH entries, read when a pixel is taken and
// written when it leaves the intake register; its contents are undefined after
// reset and the first two rows of each frame fill it. Configuration writes take
// effect at once and belong between frames.
module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] pixel_value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] center_row, [25:16] center_col, [36:26] edge_magnitude, [39:37] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,   // frame_last
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    sem_job_t    push_job;
    sem_job_t    head_job;
    sem_q_ctrl_t q_ctrl;
    sem_q_stat_t q_stat;
    logic        push;
    logic        pop;

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_stat.full),
        .q_push    (push),
        .q_job     (push_job)
    );

    sem_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (q_ctrl),
        .wr_job (push_job),
        .rd_job (head_job),
        .stat   (q_stat)
    );

    sem_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_job    (head_job),
        .q_empty  (q_stat.empty),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/sem_checker.sv
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks of the Sobel edge magnitude block, bound to the top level.
// ----------------------------------------------------------------------------
module sem_checker
    import sem_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result request changed");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[36:26] <= 11'd1443)
        else $error("edge magnitude out of range");

    a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:0] != 16'd0)
        else $error("result for a border row");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:37] == 3'b000)
        else $error("padding bits of result request not zero");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);
